// File: hw/rtl/multi_led_blink_controller_macros.svh
// Assertion helpers for the LED blink controller.
// Both expect clk and arst_n in the scope where they are used.
`ifndef MULTI_LED_BLINK_CONTROLLER_MACROS_SVH
`define MULTI_LED_BLINK_CONTROLLER_MACROS_SVH

// Property must hold on every clock edge out of reset.
`define MLB_ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true on a clock edge out of reset.
`define MLB_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/mlb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlb_pkg
// Shared types and constants of the multi-channel LED blink controller.
// ----------------------------------------------------------------------------
package mlb_pkg;

	localparam int REQ_W    = 2;
	localparam int CHAN_W   = 3;
	localparam int COUNT_W  = 8;
	localparam int DUTY_W   = 7;
	localparam int PERIOD_W = 16;
	localparam int MASK_W   = 7;
	localparam int TICK_W   = 10;
	localparam int HALVES_W = 9;
	localparam int PROD_W   = PERIOD_W + DUTY_W;

	localparam logic [TICK_W-1:0] TICK_RESET = 10'd5;
	localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

	// floor(x / 100) == (x * DIV_RECIP) >> DIV_SHIFT for every x below 2**23
	localparam int                DIV_SHIFT = 30;
	localparam int                RECIP_W   = 24;
	localparam logic [RECIP_W-1:0] DIV_RECIP = 24'd10737419;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_BLINK = 2'd1,
		REQ_ON    = 2'd2,
		REQ_OFF   = 2'd3
	} mlb_req_t;

	// One channel's entry in the state memory.
	typedef struct packed {
		logic [PERIOD_W-1:0] time_left;
		logic [HALVES_W-1:0] halves_left;
		logic [PERIOD_W-1:0] on_time;
		logic [PERIOD_W-1:0] off_time;
	} mlb_entry_t;

endpackage

// File: hw/rtl/mlb_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlb_req_if
// Request channel: tick, start blink, force on, force off.
// ----------------------------------------------------------------------------
interface mlb_req_if import mlb_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [REQ_W-1:0]    req_type;
	logic [CHAN_W-1:0]   channel;
	logic [COUNT_W-1:0]  flash_count;
	logic [DUTY_W-1:0]   duty_percent;
	logic [PERIOD_W-1:0] period_ms;

	modport source (
		output valid, req_type, channel, flash_count, duty_percent, period_ms,
		input  ready
	);
	modport sink (
		input  valid, req_type, channel, flash_count, duty_percent, period_ms,
		output ready
	);
endinterface

// File: hw/rtl/mlb_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlb_rsp_if
// Result channel: lit and blinking masks after each request.
// ----------------------------------------------------------------------------
interface mlb_rsp_if import mlb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] lit_mask;
	logic [MASK_W-1:0] blinking_mask;

	modport source (
		output valid, lit_mask, blinking_mask,
		input  ready
	);
	modport sink (
		input  valid, lit_mask, blinking_mask,
		output ready
	);
endinterface

// File: hw/rtl/mlb_state_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlb_state_mem
// Per-channel state memory, one write and one read port, registered read.
// Entries never written read back as zero.
// ----------------------------------------------------------------------------
module mlb_state_mem import mlb_pkg::*; #(
	parameter int DEPTH = 7,
	parameter int AW    = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output mlb_entry_t    rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  mlb_entry_t    wr_data
);

	mlb_entry_t       mem_q [DEPTH];
	mlb_entry_t       rd_data_q;
	logic [DEPTH-1:0] vld_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

// File: hw/rtl/mlb_duty_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlb_duty_calc
// Two-stage on/off time split: period * duty, then divide by 100 through a
// reciprocal multiply. Both results come from the second-stage registers.
// ----------------------------------------------------------------------------
module mlb_duty_calc import mlb_pkg::*; (
	input  logic                clk,
	input  logic                load,
	input  logic [PERIOD_W-1:0] period_ms,
	input  logic [DUTY_W-1:0]   duty_percent,
	output logic [PERIOD_W-1:0] on_time,
	output logic [PERIOD_W-1:0] off_time
);

	localparam int FULL_W = PROD_W + RECIP_W;

	logic [DUTY_W-1:0]   duty_sat;
	logic [PROD_W-1:0]   prod_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic [FULL_W-1:0]   full;
	logic [PERIOD_W-1:0] on_val;
	logic [PERIOD_W-1:0] on_s2;
	logic [PERIOD_W-1:0] off_s2;

	assign duty_sat = (duty_percent > DUTY_MAX) ? DUTY_MAX : duty_percent;

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1   <= PROD_W'(period_ms) * PROD_W'(duty_sat);
			period_s1 <= period_ms;
		end
	end

	// quotient never exceeds the period, so 16 bits hold it
	assign full   = FULL_W'(prod_s1) * FULL_W'(DIV_RECIP);
	assign on_val = full[DIV_SHIFT +: PERIOD_W];

	always_ff @(posedge clk) begin
		on_s2  <= on_val;
		off_s2 <= period_s1 - on_val;
	end

	assign on_time  = on_s2;
	assign off_time = off_s2;

endmodule

// File: hw/rtl/multi_led_blink_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_led_blink_controller
// Per-channel LED blink engine with timing state held in a memory.
//
//   channel   | dir | handshake   | beat
//   ----------+-----+-------------+--------------------------------------
//   req       | in  | valid/ready | req_type, channel, count, duty, period
//   rsp       | out | valid/ready | lit_mask, blinking_mask
//   tick_ms   | in  | write only  | tick_ms_wdata on tick_ms_we
//
// A tick sweeps the state memory one channel a cycle, each write-back in the
// cycle after its read. Start blink passes the two multiply stages, then the
// write-back; force on/off and ignored channels go straight to the result.
// Reset clears light and mode bits and the memory valid bits at once.
// A result waits in the output register; the next request is taken
// meanwhile and its result holds until the slot frees.
// ----------------------------------------------------------------------------
`include "multi_led_blink_controller_macros.svh"

module multi_led_blink_controller import mlb_pkg::*; #(
	parameter int CHANNELS = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_ms_we,
	input  logic [TICK_W-1:0] tick_ms_wdata,
	mlb_req_if.sink           req,
	mlb_rsp_if.source         rsp
);

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CW = $clog2(CHANNELS + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(CHANNELS);
	localparam logic [5:0]    CH_LIM   = 6'(CHANNELS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_MUL,
		S_BWR,
		S_EMIT
	} state_t;

	state_t              state_q;
	logic [TICK_W-1:0]   tick_ms_q;
	logic [CHANNELS-1:0] lit_q;
	logic [CHANNELS-1:0] lim_q;
	logic [CHANNELS-1:0] unl_q;
	logic [CW-1:0]       rc_q;
	logic                v_s1;
	logic [AW-1:0]       a_s1;
	logic [AW-1:0]       ch_q;
	logic [COUNT_W-1:0]  n_q;
	logic                out_valid_q;
	logic [MASK_W-1:0]   lit_mask_q;
	logic [MASK_W-1:0]   blink_mask_q;

	logic                accept;
	logic                emit_fire;
	mlb_req_t            req_code;
	logic                ch_ok;
	logic [AW-1:0]       ch_addr;
	logic [MASK_W-1:0]   lit_mask;
	logic [MASK_W-1:0]   blink_mask;

	logic                mem_rd_en;
	logic [AW-1:0]       mem_rd_addr;
	mlb_entry_t          mem_rd;
	logic                mem_wr_en;
	logic [AW-1:0]       mem_wr_addr;
	mlb_entry_t          mem_wr;

	logic [PERIOD_W-1:0] on_time;
	logic [PERIOD_W-1:0] off_time;

	mlb_entry_t          tk_entry;
	logic                tk_lit;
	logic                tk_lim;
	logic                tk_unl;
	logic                cur_lit;
	logic                cur_lim;
	logic                cur_unl;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign req_code = mlb_req_t'(req.req_type);
	assign ch_ok    = ({3'b000, req.channel} < CH_LIM);
	assign ch_addr  = AW'(req.channel);
	// load the output register once it is empty or being drained
	assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || rsp.ready);

	// masks show only the first seven channels
	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_on
			assign lit_mask[g]   = lit_q[g];
			assign blink_mask[g] = lim_q[g] | unl_q[g];
		end else begin : g_off
			assign lit_mask[g]   = 1'b0;
			assign blink_mask[g] = 1'b0;
		end
	end

	mlb_state_mem #(
		.DEPTH (CHANNELS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr)
	);

	mlb_duty_calc u_duty (
		.clk          (clk),
		.load         (accept && (req_code == REQ_BLINK)),
		.period_ms    (req.period_ms),
		.duty_percent (req.duty_percent),
		.on_time      (on_time),
		.off_time     (off_time)
	);

	// tick update of the channel whose entry just came out of memory
	assign cur_lit = lit_q[a_s1];
	assign cur_lim = lim_q[a_s1];
	assign cur_unl = unl_q[a_s1];

	always_comb begin
		tk_entry = mem_rd;
		tk_lit   = cur_lit;
		tk_lim   = cur_lim;
		tk_unl   = cur_unl;
		if (cur_lim && (mem_rd.halves_left == '0)) begin
			// limited blink used up: go dark and idle
			tk_lit = 1'b0;
			tk_lim = 1'b0;
		end else if (cur_lim || cur_unl) begin
			if (mem_rd.time_left != '0) begin
				if (mem_rd.time_left >= PERIOD_W'(tick_ms_q)) begin
					tk_entry.time_left = mem_rd.time_left - PERIOD_W'(tick_ms_q);
				end else begin
					tk_entry.time_left = '0;
				end
			end else begin
				// phase over: flip and reload the time of the new phase
				tk_lit             = !cur_lit;
				tk_entry.time_left = cur_lit ? mem_rd.off_time : mem_rd.on_time;
				if (cur_lim) begin
					tk_entry.halves_left = mem_rd.halves_left - 1'b1;
				end
			end
		end
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = '0;
		mem_wr_en   = 1'b0;
		mem_wr_addr = a_s1;
		mem_wr      = tk_entry;
		if (accept && (req_code == REQ_TICK)) begin
			mem_rd_en = 1'b1;
		end else if (accept && (req_code == REQ_BLINK) && ch_ok) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = ch_addr;
		end else if ((state_q == S_TICK) && (rc_q != LAST_CNT)) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = rc_q[AW-1:0];
		end
		if ((state_q == S_TICK) && v_s1) begin
			mem_wr_en = 1'b1;
		end else if (state_q == S_BWR) begin
			// keep the running phase time, restart counts and times
			mem_wr_en             = 1'b1;
			mem_wr_addr           = ch_q;
			mem_wr.time_left      = mem_rd.time_left;
			mem_wr.halves_left    = {n_q, 1'b0};
			mem_wr.on_time        = on_time;
			mem_wr.off_time       = off_time;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= ch_addr;
			n_q  <= req.flash_count;
		end
		if (mem_rd_en) begin
			a_s1 <= mem_rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			tick_ms_q    <= TICK_RESET;
			lit_q        <= '0;
			lim_q        <= '0;
			unl_q        <= '0;
			rc_q         <= '0;
			v_s1         <= 1'b0;
			out_valid_q  <= 1'b0;
			lit_mask_q   <= '0;
			blink_mask_q <= '0;
		end else begin
			if (tick_ms_we) begin
				tick_ms_q <= tick_ms_wdata;
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_code)
							REQ_TICK: begin
								rc_q    <= CW'(1);
								v_s1    <= 1'b1;
								state_q <= S_TICK;
							end
							REQ_BLINK: begin
								state_q <= ch_ok ? S_MUL : S_EMIT;
							end
							REQ_ON: begin
								if (ch_ok) begin
									lit_q[ch_addr] <= 1'b1;
								end
								state_q <= S_EMIT;
							end
							REQ_OFF: begin
								if (ch_ok) begin
									lit_q[ch_addr] <= 1'b0;
								end
								state_q <= S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_TICK: begin
					if (v_s1) begin
						lit_q[a_s1] <= tk_lit;
						lim_q[a_s1] <= tk_lim;
						unl_q[a_s1] <= tk_unl;
					end
					if (rc_q != LAST_CNT) begin
						rc_q <= rc_q + 1'b1;
						v_s1 <= 1'b1;
					end else begin
						v_s1    <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_MUL: begin
					state_q <= S_BWR;
				end
				S_BWR: begin
					lim_q[ch_q] <= (n_q != '0);
					unl_q[ch_q] <= (n_q == '0);
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (emit_fire) begin
						lit_mask_q   <= lit_mask;
						blink_mask_q <= blink_mask;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.lit_mask      = lit_mask_q;
	assign rsp.blinking_mask = blink_mask_q;

	`MLB_ASSERT_NEVER(a_mode_excl, |(lim_q & unl_q), "channel both limited and unlimited")
	`MLB_ASSERT_HOLDS(a_idle_no_sweep, (state_q == S_IDLE) |-> !v_s1, "sweep left in flight")
	`MLB_ASSERT_NEVER(a_rw_clash, mem_rd_en && mem_wr_en && (mem_rd_addr == mem_wr_addr), "read and write hit the same entry")
	`MLB_ASSERT_HOLDS(a_bwr_order, (state_q == S_BWR) |-> ($past(state_q) == S_MUL), "write-back without multiply stage")

endmodule
